### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// implication checked every clock edge outside reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication failed");

`endif

### design/arct_pkg.sv
// ----------------------------------------------------------------------------
// arct_pkg
// types, codes and sizes shared by the address range claim table
// ----------------------------------------------------------------------------
package arct_pkg;

   localparam int RANGE_SLOTS = 64;
   localparam int SLOT_W      = $clog2(RANGE_SLOTS);
   localparam int CNT_W       = $clog2(RANGE_SLOTS + 1);

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NULL      = 3'd1;
   localparam logic [2:0] ST_WRAPS     = 3'd2;
   localparam logic [2:0] ST_SELF      = 3'd3;
   localparam logic [2:0] ST_EMPTY     = 3'd4;
   localparam logic [2:0] ST_ACTIVE    = 3'd5;
   localparam logic [2:0] ST_EXHAUSTED = 3'd6;
   localparam logic [2:0] ST_FULL      = 3'd7;

   localparam logic OP_ADD     = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   typedef struct packed {
      logic        opcode;
      logic [63:0] range_start;
      logic [63:0] range_length;
      logic        last_range;
      logic [63:0] release_id;
   } item_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [63:0] granted_id;
   } result_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_SCAN,
      S_STORE,
      S_FINISH,
      S_RELEASE
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic load;
      logic chk_apply;
      logic scan_step;
      logic store;
      logic finish;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic op;
      logic last;
      logic skip;
      logic bad;
      logic scan_done;
   } stat_type;

endpackage

### design/arct_ctrl.sv
// ----------------------------------------------------------------------------
// arct_ctrl
// sequencer for range checks, slot scans, commits and releases
// ----------------------------------------------------------------------------
module arct_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  arct_pkg::stat_type stat,
   output arct_pkg::cmd_type  cmd,
   output logic               busy
);
   import arct_pkg::*;

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_CHECK;
         end
         S_CHECK: begin
            priority if (stat.op == OP_RELEASE) state_in = S_RELEASE;
            else if (stat.skip || stat.bad) state_in = stat.last ? S_FINISH : S_IDLE;
            else state_in = S_SCAN;
         end
         S_SCAN: begin
            if (stat.scan_done) state_in = S_STORE;
         end
         S_STORE: begin
            state_in = stat.last ? S_FINISH : S_IDLE;
         end
         S_FINISH: begin
            state_in = S_IDLE;
         end
         S_RELEASE: begin
            if (stat.scan_done) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd = '0;
      busy = (state_ff != S_IDLE);
      unique case (state_ff)
         S_IDLE:    cmd.load = start;
         S_CHECK:   cmd.chk_apply = (stat.op == OP_ADD);
         S_SCAN:    cmd.scan_step = 1'b1;
         S_STORE:   cmd.store = 1'b1;
         S_FINISH:  cmd.finish = 1'b1;
         S_RELEASE: cmd.scan_step = 1'b1;
         default:   cmd = '0;
      endcase
   end

endmodule

### design/arct_dp.sv
// ----------------------------------------------------------------------------
// arct_dp
// slot memories, slot flags, claim flags and the compare datapath
// ----------------------------------------------------------------------------
module arct_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  arct_pkg::item_type   req_item,
   input  arct_pkg::cmd_type    cmd,
   output arct_pkg::stat_type   stat,
   output logic                 rsp_valid,
   output arct_pkg::result_type rsp_result
);
   import arct_pkg::*;

   // slot memories
   logic [63:0] mem_start [RANGE_SLOTS];
   logic [63:0] mem_end   [RANGE_SLOTS];
   logic [63:0] mem_owner [RANGE_SLOTS];
   logic [63:0] rd_start_ff, rd_end_ff, rd_owner_ff;

   logic [RANGE_SLOTS-1:0] used_ff, used_in;
   logic [RANGE_SLOTS-1:0] pend_ff, pend_in;

   item_type          item_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              self_ff, self_in;
   logic              act_ff, act_in;
   logic              free_ff, free_in;
   logic [SLOT_W-1:0] free_idx_ff, free_idx_in;

   logic [2:0]  first_err_ff, first_err_in;
   logic        hit_ff, hit_in;
   logic        seen_ff, seen_in;
   logic        ranout_ff, ranout_in;
   logic [63:0] next_id_ff, next_id_in;

   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_ff, rsp_in;

   logic [63:0]       item_end;
   logic [CNT_W-1:0]  chk_cnt;
   logic [SLOT_W-1:0] chk_idx;
   logic              chk_valid;
   logic              rd_issue;
   logic              overlap;
   logic [2:0]        fin_status;

   assign item_end  = item_ff.range_start + item_ff.range_length;
   assign chk_cnt   = cnt_ff - CNT_W'(1);
   assign chk_idx   = chk_cnt[SLOT_W-1:0];
   assign chk_valid = cmd.scan_step && (cnt_ff != '0);
   assign rd_issue  = cmd.scan_step && (cnt_ff < CNT_W'(RANGE_SLOTS));
   assign overlap   = (item_ff.range_start < rd_end_ff) && (rd_start_ff < item_end);

   assign stat.op        = item_ff.opcode;
   assign stat.last      = item_ff.last_range;
   assign stat.skip      = (item_ff.range_length == '0) || (first_err_ff != ST_OK);
   assign stat.bad       = (item_ff.range_start == '0) ||
                           (item_ff.range_length > ~item_ff.range_start);
   assign stat.scan_done = (cnt_ff == CNT_W'(RANGE_SLOTS));

   // finishing status by priority
   always_comb begin
      priority if (first_err_ff != ST_OK) fin_status = first_err_ff;
      else if (!seen_ff) fin_status = ST_EMPTY;
      else if (hit_ff) fin_status = ST_ACTIVE;
      else if (next_id_ff == '0 || next_id_ff == '1) fin_status = ST_EXHAUSTED;
      else if (ranout_ff) fin_status = ST_FULL;
      else fin_status = ST_OK;
   end

   // memory write on store, read one slot per scan step
   always_ff @(posedge clock) begin
      if (cmd.store && !self_ff && free_ff) begin
         mem_start[free_idx_ff] <= item_ff.range_start;
         mem_end[free_idx_ff]   <= item_end;
         mem_owner[free_idx_ff] <= next_id_ff;
      end
      if (rd_issue) begin
         rd_start_ff <= mem_start[cnt_ff[SLOT_W-1:0]];
         rd_end_ff   <= mem_end[cnt_ff[SLOT_W-1:0]];
         rd_owner_ff <= mem_owner[cnt_ff[SLOT_W-1:0]];
      end
   end

   // item register
   always_ff @(posedge clock) begin
      if (cmd.load) item_ff <= req_item;
   end

   // scan compare, slot flags and claim flags
   always_comb begin
      used_in      = used_ff;
      pend_in      = pend_ff;
      self_in      = self_ff;
      act_in       = act_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      first_err_in = first_err_ff;
      hit_in       = hit_ff;
      seen_in      = seen_ff;
      ranout_in    = ranout_ff;
      next_id_in   = next_id_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      if (cmd.load) begin
         self_in = 1'b0;
         act_in  = 1'b0;
         free_in = 1'b0;
      end
      // basic range checks
      if (cmd.chk_apply && !stat.skip && stat.bad) begin
         first_err_in = (item_ff.range_start == '0) ? ST_NULL : ST_WRAPS;
      end
      // one slot per step
      if (chk_valid) begin
         if (item_ff.opcode == OP_RELEASE) begin
            if (used_ff[chk_idx] && !pend_ff[chk_idx] &&
                rd_owner_ff == item_ff.release_id) begin
               used_in[chk_idx] = 1'b0;
            end
         end else begin
            if (used_ff[chk_idx]) begin
               if (overlap && pend_ff[chk_idx]) self_in = 1'b1;
               if (overlap && !pend_ff[chk_idx]) act_in = 1'b1;
            end else if (!free_ff) begin
               free_in     = 1'b1;
               free_idx_in = chk_idx;
            end
         end
      end
      // take the range
      if (cmd.store) begin
         if (self_ff) begin
            first_err_in = ST_SELF;
         end else begin
            seen_in = 1'b1;
            if (act_ff) hit_in = 1'b1;
            if (free_ff) begin
               used_in[free_idx_ff] = 1'b1;
               pend_in[free_idx_ff] = 1'b1;
            end else begin
               ranout_in = 1'b1;
            end
         end
      end
      // commit or discard the pending slots
      if (cmd.finish) begin
         for (int i = 0; i < RANGE_SLOTS; i++) begin
            if (used_ff[i] && pend_ff[i]) begin
               pend_in[i] = 1'b0;
               if (fin_status != ST_OK) used_in[i] = 1'b0;
            end
         end
         rsp_valid_in      = 1'b1;
         rsp_in.status     = fin_status;
         rsp_in.granted_id = (fin_status == ST_OK) ? next_id_ff : '0;
         if (fin_status == ST_OK) next_id_in = next_id_ff + 64'd1;
         first_err_in = ST_OK;
         hit_in       = 1'b0;
         seen_in      = 1'b0;
         ranout_in    = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         pend_ff      <= '0;
         cnt_ff       <= '0;
         first_err_ff <= ST_OK;
         hit_ff       <= 1'b0;
         seen_ff      <= 1'b0;
         ranout_ff    <= 1'b0;
         next_id_ff   <= 64'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         used_ff      <= used_in;
         pend_ff      <= pend_in;
         cnt_ff       <= cmd.load ? '0 : (cmd.scan_step ? cnt_ff + CNT_W'(1) : cnt_ff);
         first_err_ff <= first_err_in;
         hit_ff       <= hit_in;
         seen_ff      <= seen_in;
         ranout_ff    <= ranout_in;
         next_id_ff   <= next_id_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // scan results and result payload
   always_ff @(posedge clock) begin
      self_ff     <= self_in;
      act_ff      <= act_in;
      free_ff     <= free_in;
      free_idx_ff <= free_idx_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_ff;

endmodule

### design/address_range_claim_table.sv
// ----------------------------------------------------------------------------
// address_range_claim_table
// exclusive address range claims grouped under claim ids
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. An add item that is
// skipped (zero length, or after an error in the claim) or invalid goes from
// the check state back to idle, or through the finish state when it is the
// last range. A checked add item reads one table slot per cycle from the slot
// memory in the scan state, then passes the store state and, when it is the
// last range, the finish state. A release scans the owner memory the same way
// and then returns to idle. The last range of a claim gives one result,
// strobed by rsp_valid for a single cycle; the receiver cannot stall it, so
// it must take it in that cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module address_range_claim_table (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  arct_pkg::item_type   req_item,
   output logic                 rsp_valid,
   output arct_pkg::result_type rsp_result
);
   import arct_pkg::*;

   cmd_type  cmd;
   stat_type stat;
   logic     rsp_fail;

   // sequencer
   arct_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   // table and compare datapath
   arct_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_item   (req_item),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_valid  (rsp_valid),
      .rsp_result (rsp_result)
   );

   // failed claim strobe
   assign rsp_fail = rsp_valid && (rsp_result.status != ST_OK);

   // checks
   `ASSERT_CLK(a_accept_busy, clock, reset, (start && !busy) |=> busy)
   `ASSERT_CLK(a_rsp_single, clock, reset, rsp_valid |=> !rsp_valid)
   `ASSERT_IMPLY(a_rsp_idle, clock, reset, rsp_valid, !busy)
   `ASSERT_IMPLY(a_fail_zero_id, clock, reset, rsp_fail, rsp_result.granted_id == '0)

endmodule
